[sv/block_bitmap_allocator_macros.svh]
// ---------------------------------------------------------------------------
// Block bitmap allocator assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked at every clock edge out of reset
`define BBA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge out of reset
`define BBA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bba_pkg.sv]
// ---------------------------------------------------------------------------
// Block bitmap allocator package
// Shared widths, codes, payload types and controller/datapath interface.
// ---------------------------------------------------------------------------
package bba_pkg;

    localparam int BLK_W             = 12;
    localparam int TOTAL_W           = 13;
    localparam int OP_W              = 2;
    localparam int STAT_W            = 2;
    localparam int NUM_BLOCKS_DEF    = 4096;
    localparam int MAP_WORD_BITS_DEF = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

    // Request opcodes; the fourth code only echoes the block number
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_READ  = 2'd2
    } bba_op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } bba_status_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [BLK_W-1:0] block_number;
    } bba_req_t;

    typedef struct packed {
        logic [BLK_W-1:0]   result_block;
        logic               bit_value;
        logic [STAT_W-1:0]  status;
        logic [TOTAL_W-1:0] free_count;
    } bba_rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_FIX,
        S_BITOP,
        S_FINISH
    } bba_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic scan;
        logic mul;
        logic fix;
        logic bitop;
        logic load;
    } bba_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic            clear_last;
        logic [OP_W-1:0] req_op;
        logic            in_range;
        logic            scan_stop;
        logic            out_free;
    } bba_stat_t;

endpackage

[sv/bba_ctrl.sv]
// ---------------------------------------------------------------------------
// Block bitmap allocator controller
// Sequences the clearing pass, the bitmap scan and the free/read steps.
// ---------------------------------------------------------------------------
module bba_ctrl
    import bba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  bba_stat_t stat,
    output bba_cmd_t  cmd
);

    bba_state_t state_reg;
    bba_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    priority if (stat.req_op == OP_ALLOC)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (stat.req_op == OP_FREE || stat.req_op == OP_READ)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_stop)
                begin
                    state_next = S_FINISH;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = stat.in_range ? S_BITOP : S_FINISH;
            end
            S_BITOP:
            begin
                cmd.bitop  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

[sv/bba_datapath.sv]
// ---------------------------------------------------------------------------
// Block bitmap allocator datapath
// Bitmap memory, used count, word scan, block-to-word split, result register.
// ---------------------------------------------------------------------------
module bba_datapath
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS    = NUM_BLOCKS_DEF,
    parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  bba_req_t            req,
    input  logic                cfg_we,
    input  logic [TOTAL_W-1:0]  cfg_data,
    input  logic                rsp_stall,
    output logic                rsp_valid,
    output bba_rsp_t            rsp,
    input  bba_cmd_t            cmd,
    output bba_stat_t           stat
);

    localparam int MAP_WORDS = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SEL_W     = $clog2(MAP_WORD_BITS);
    localparam int CAP_W     = $clog2(NUM_BLOCKS + 1);
    localparam int CNT_W     = (CAP_W > TOTAL_W) ? CAP_W : TOTAL_W;
    localparam int RECIP     = (1 << BLK_W) / MAP_WORD_BITS;
    localparam int Q_W       = BLK_W - SEL_W + 1;
    localparam int PROD_W    = BLK_W + Q_W;

    localparam logic [CNT_W-1:0]   BLOCK_CAP = CNT_W'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0]   WORD_STEP = CNT_W'(MAP_WORD_BITS);
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(MAP_WORDS - 1);
    localparam logic [BLK_W:0]     WORD_DIV  = (BLK_W + 1)'(MAP_WORD_BITS);
    localparam logic [PROD_W-1:0]  RECIP_X   = PROD_W'(RECIP);

    logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];

    logic [TOTAL_W-1:0]       total_blocks_reg;
    logic [WADDR_W-1:0]       clr_addr_reg;
    logic [CNT_W-1:0]         used_total_reg;
    logic [CNT_W-1:0]         used_total_next;
    logic [OP_W-1:0]          op_reg;
    logic [BLK_W-1:0]         blk_reg;
    logic [WADDR_W-1:0]       eval_addr_reg;
    logic [CNT_W-1:0]         base_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [WADDR_W-1:0]       word_reg;
    logic [SEL_W-1:0]         sel_reg;
    logic [BLK_W-1:0]         res_block_reg;
    logic                     res_bit_reg;
    logic [STAT_W-1:0]        res_status_reg;
    logic [MAP_WORD_BITS-1:0] rd_data_reg;
    bba_rsp_t                 rsp_reg;
    logic                     rsp_valid_reg;

    logic [CNT_W-1:0]         total_m;
    logic [CNT_W-1:0]         rem;
    logic [MAP_WORD_BITS-1:0] word_mask;
    logic [MAP_WORD_BITS-1:0] free_vec;
    logic                     found;
    logic [SEL_W-1:0]         free_idx;
    logic [CNT_W-1:0]         base_step;
    logic [CNT_W-1:0]         found_block;
    logic                     scan_stop;
    logic [WADDR_W-1:0]       scan_rd_addr;
    logic [Q_W-1:0]           q_est;
    logic [BLK_W:0]           qw;
    logic [BLK_W:0]           r_raw;
    logic                     r_big;
    logic [Q_W:0]             q_fix;
    logic [BLK_W:0]           r_fix;
    logic                     in_range;
    logic                     bit_hit;
    logic                     free_hit;
    logic [CNT_W-1:0]         free_cnt_full;
    logic [TOTAL_W-1:0]       free_cnt;
    logic                     mem_we;
    logic [WADDR_W-1:0]       mem_waddr;
    logic [MAP_WORD_BITS-1:0] mem_wdata;
    logic [WADDR_W-1:0]       rd_addr;

    // Clamp the configured total to the bitmap size
    assign total_m = (CNT_W'(total_blocks_reg) > BLOCK_CAP) ? BLOCK_CAP
                                                            : CNT_W'(total_blocks_reg);

    // Scan: lowest free bit of the current word that lies below the total
    assign rem = total_m - base_reg;

    always_comb
    begin
        for (int s = 0; s < MAP_WORD_BITS; s++)
        begin
            word_mask[s] = (CNT_W'(s) < rem);
        end
    end

    assign free_vec = ~rd_data_reg & word_mask;
    assign found    = |free_vec;

    always_comb
    begin
        free_idx = '0;
        for (int s = MAP_WORD_BITS - 1; s >= 0; s--)
        begin
            if (free_vec[s])
            begin
                free_idx = SEL_W'(s);
            end
        end
    end

    assign base_step    = base_reg + WORD_STEP;
    assign found_block  = base_reg + CNT_W'(free_idx);
    assign scan_stop    = found || (base_step >= total_m);
    assign scan_rd_addr = (eval_addr_reg == LAST_WORD) ? eval_addr_reg
                                                       : eval_addr_reg + 1'b1;

    // Split block number into word and bit: reciprocal estimate, one correction
    assign q_est = prod_reg[PROD_W-1:BLK_W];
    assign qw    = (BLK_W + 1)'(q_est) * WORD_DIV;
    assign r_raw = {1'b0, blk_reg} - qw;
    assign r_big = (r_raw >= WORD_DIV);
    assign q_fix = r_big ? ({1'b0, q_est} + 1'b1) : {1'b0, q_est};
    assign r_fix = r_big ? (r_raw - WORD_DIV) : r_raw;

    assign in_range = (CNT_W'(blk_reg) < total_m);
    assign bit_hit  = rd_data_reg[sel_reg];
    assign free_hit = cmd.bitop && (op_reg == OP_FREE) && bit_hit;

    // Free count after the operation, saturating at zero
    assign free_cnt_full = (total_m > used_total_reg) ? (total_m - used_total_reg) : '0;
    assign free_cnt      = TOTAL_W'(free_cnt_full);

    // Used count update
    always_comb
    begin
        used_total_next = used_total_reg;
        priority if (cmd.scan && found)
        begin
            used_total_next = used_total_reg + 1'b1;
        end
        else if (free_hit && (used_total_reg != '0))
        begin
            used_total_next = used_total_reg - 1'b1;
        end
    end

    // Bitmap write port: clear pass, allocate set, free clear
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        priority if (cmd.clear_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.scan && found)
        begin
            mem_we    = 1'b1;
            mem_waddr = eval_addr_reg;
            mem_wdata = rd_data_reg | (MAP_WORD_BITS'(1) << free_idx);
        end
        else if (free_hit)
        begin
            mem_we    = 1'b1;
            mem_waddr = word_reg;
            mem_wdata = rd_data_reg & ~(MAP_WORD_BITS'(1) << sel_reg);
        end
    end

    // Bitmap read address: next scan word, split word, else word zero
    always_comb
    begin
        priority if (cmd.scan)
        begin
            rd_addr = scan_rd_addr;
        end
        else if (cmd.fix)
        begin
            rd_addr = WADDR_W'(q_fix);
        end
        else
        begin
            rd_addr = '0;
        end
    end

    // Bitmap memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= map_mem[rd_addr];
    end

    // Control state: configuration, clear pointer, used count, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_blocks_reg <= TOTAL_RESET;
            clr_addr_reg     <= '0;
            used_total_reg   <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                total_blocks_reg <= cfg_data;
            end
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            used_total_reg <= used_total_next;
            if (cmd.load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Transaction payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg         <= req.op;
            blk_reg        <= req.block_number;
            eval_addr_reg  <= '0;
            base_reg       <= '0;
            res_block_reg  <= (req.op == OP_ALLOC) ? '0 : req.block_number;
            res_bit_reg    <= 1'b0;
            res_status_reg <= STAT_OK;
        end
        if (cmd.scan)
        begin
            priority if (found)
            begin
                res_block_reg <= BLK_W'(found_block);
            end
            else if (scan_stop)
            begin
                res_status_reg <= STAT_FULL;
            end
            else
            begin
                eval_addr_reg <= eval_addr_reg + 1'b1;
                base_reg      <= base_step;
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(blk_reg) * RECIP_X;
        end
        if (cmd.fix)
        begin
            word_reg <= WADDR_W'(q_fix);
            sel_reg  <= SEL_W'(r_fix);
            if (!in_range)
            begin
                res_status_reg <= STAT_RANGE;
            end
        end
        if (cmd.bitop && (op_reg == OP_READ))
        begin
            res_bit_reg <= bit_hit;
        end
        if (cmd.load)
        begin
            rsp_reg.result_block <= res_block_reg;
            rsp_reg.bit_value    <= res_bit_reg;
            rsp_reg.status       <= res_status_reg;
            rsp_reg.free_count   <= free_cnt;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    assign stat.clear_last = (clr_addr_reg == LAST_WORD);
    assign stat.req_op     = req.op;
    assign stat.in_range   = in_range;
    assign stat.scan_stop  = scan_stop;
    assign stat.out_free   = !rsp_valid_reg || !rsp_stall;

endmodule

[sv/block_bitmap_allocator.sv]
// ---------------------------------------------------------------------------
// Block bitmap allocator
// First-fit block allocator over a used-bit bitmap with a used-block count.
//
// Each request (allocate, free, read) gives exactly one response carrying
// the free count after the operation. Allocate examines bitmap words up to
// the first word with a free block below the total, at most MAP_WORDS (128 at
// the default 4096 blocks in 32-bit words), one word per cycle through the
// bitmap memory's single read port. Free and read split the block number and
// skip the bit step when it is out of range; the unused opcode goes straight
// to the response. A new request is taken while the previous response waits
// in the output register. After reset a clearing pass zeros all MAP_WORDS
// bitmap words (128 by default) with req_stall high; total_blocks may be
// written meanwhile.
// ---------------------------------------------------------------------------
module block_bitmap_allocator
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS    = NUM_BLOCKS_DEF,
    parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  bba_req_t           req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output bba_rsp_t           rsp,
    input  logic               cfg_we,
    input  logic [TOTAL_W-1:0] cfg_data
);

    bba_cmd_t  cmd;
    bba_stat_t stat;

    // Sequencer
    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Bitmap, counters and result register
    bba_datapath #(
        .NUM_BLOCKS    (NUM_BLOCKS),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[sv/bba_checker.sv]
// ---------------------------------------------------------------------------
// Block bitmap allocator port checker
// Watches the allocator's ports for ordering and response consistency.
// ---------------------------------------------------------------------------
`include "block_bitmap_allocator_macros.svh"

module bba_checker
    import bba_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input bba_rsp_t           rsp
);

    logic       req_fire;
    logic       rsp_fire;
    logic       rsp_wait;
    logic       rsp_full;
    logic       full_zero;
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    assign req_fire = req_valid && !req_stall;
    assign rsp_fire = rsp_valid && !rsp_stall;
    assign rsp_wait = rsp_valid && rsp_stall;

    // A full response carries no free block and block number zero
    assign rsp_full  = rsp_valid && (rsp.status == STAT_FULL);
    assign full_zero = (rsp.free_count == '0) && (rsp.result_block == '0);

    // Count transactions accepted but not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (req_fire && !rsp_fire)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (rsp_fire && !req_fire)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `BBA_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp), "stalled response changed")
    `BBA_ASSERT_NEXT(a_busy_after_accept, req_fire, req_stall, "request taken while busy")
    `BBA_ASSERT_IMP(a_rsp_has_request, rsp_valid, pending_reg != 2'd0, "response without request")
    `BBA_ASSERT_IMP(a_pending_bound, 1'b1, pending_reg != 2'd3, "too many in flight")
    `BBA_ASSERT_IMP(a_full_consistent, rsp_full, full_zero, "full status with free blocks")

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (.*);
